@@ rtl/core/kmc_pkg.sv @@
// Package with the types and constants shared by the k-means engine.
`timescale 1ns / 1ps
package kmc_pkg;

    localparam int MAX_POINTS   = 4096;
    localparam int MAX_CLUSTERS = 16;

    localparam int CRD_W  = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 13;
    localparam int SUM_W  = CRD_W + CNT_W;
    localparam int DIST_W = 2 * CRD_W + 1;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = CNT_W + 1;

    localparam logic CFG_CLUSTERS = 1'b0;
    localparam logic CFG_ITERS    = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_PICK,
        S_DIVX,
        S_DIVZ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [CRD_W-1:0] point_x;
        logic signed [CRD_W-1:0] point_z;
        logic [IDX_W-1:0]        centroid_slot;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]        centroid_index;
        logic signed [CRD_W-1:0] centroid_x;
        logic signed [CRD_W-1:0] centroid_z;
        logic [CNT_W-1:0]        member_count;
        logic                    cluster_empty;
        logic                    last_result;
    } t_out_res;

    typedef struct packed {
        logic                    valid;
        logic                    best_v;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] z;
        logic [DIST_W-1:0]       best_d;
        logic [IDX_W-1:0]        best_idx;
    } t_token;

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        idx;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] z;
    } t_acc;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        idx;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] z;
    } t_cwr;

    typedef struct packed {
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cz;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sz;
        logic [CNT_W-1:0]        tally;
    } t_cell_stat;

endpackage

@@ rtl/core/kmc_cell.sv @@
// One cluster cell: holds a centroid and its sums, and compares passing points.
`timescale 1ns / 1ps
module kmc_cell
    import kmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  logic             i_active,
    input  logic             i_clr,
    input  t_token           i_tok,
    output t_token           o_tok,
    input  t_acc             i_acc,
    input  t_cwr             i_cwr,
    output t_cell_stat       o_stat
);

    logic signed [CRD_W:0]   dx, dz;
    logic [CRD_W-1:0]        ax, az;
    logic [DIST_W-1:0]       dsq;
    logic                    take;
    t_token                  r_t1, r_t2, n_t2;
    logic [2*CRD_W-1:0]      r_sqx, r_sqz;
    logic signed [CRD_W-1:0] r_cx, r_cz;
    logic signed [SUM_W-1:0] r_sx, r_sz;
    logic [CNT_W-1:0]        r_tally;

    always_comb begin
        dx = {i_tok.x[CRD_W-1], i_tok.x} - {r_cx[CRD_W-1], r_cx};
        dz = {i_tok.z[CRD_W-1], i_tok.z} - {r_cz[CRD_W-1], r_cz};
        ax = dx[CRD_W] ? CRD_W'(-dx) : dx[CRD_W-1:0];
        az = dz[CRD_W] ? CRD_W'(-dz) : dz[CRD_W-1:0];
    end

    // First stage squares the offsets, second adds and compares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
        end else begin
            r_t1 <= i_tok;
            r_t2 <= n_t2;
        end
        r_sqx <= ax * ax;
        r_sqz <= az * az;
    end

    always_comb begin
        dsq  = {1'b0, r_sqx} + {1'b0, r_sqz};
        take = i_active && (!r_t1.best_v || dsq < r_t1.best_d);
        n_t2 = r_t1;
        if (take) begin
            n_t2.best_v   = 1'b1;
            n_t2.best_d   = dsq;
            n_t2.best_idx = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cz    <= '0;
            r_sx    <= '0;
            r_sz    <= '0;
            r_tally <= '0;
        end else begin
            if (i_cwr.we && i_cwr.idx == i_cell_idx) begin
                r_cx <= i_cwr.x;
                r_cz <= i_cwr.z;
            end
            if (i_clr && i_active) begin
                r_sx    <= '0;
                r_sz    <= '0;
                r_tally <= '0;
            end else if (i_acc.valid && i_acc.idx == i_cell_idx) begin
                r_sx    <= r_sx + SUM_W'(i_acc.x);
                r_sz    <= r_sz + SUM_W'(i_acc.z);
                r_tally <= r_tally + 1'b1;
            end
        end
    end

    assign o_tok = r_t2;
    assign o_stat = '{cx: r_cx, cz: r_cz, sx: r_sx, sz: r_sz, tally: r_tally};

endmodule

@@ rtl/core/kmc_div.sv @@
// Bit-serial restoring divider giving the rounded mean of a cluster sum.
`timescale 1ns / 1ps
module kmc_div
    import kmc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    input  logic [CNT_W-1:0]        i_cnt,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [CRD_W-1:0] o_q
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] r_step;
    logic              r_done, r_neg;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den, r_rem;
    logic [SUM_W-1:0]  mag;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb begin
        mag   = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : i_sum;
        trial = {r_rem, r_num[NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= STEP_W'(NUM_W);
            end else if (r_step != '0) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            // Rounding to nearest, ties away from zero: (2|s| + c) / 2c.
            r_num <= {mag, 1'b0} + NUM_W'(i_cnt);
            r_den <= {i_cnt, 1'b0};
            r_rem <= '0;
            r_neg <= i_sum[SUM_W-1];
        end else if (r_step != '0) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_busy = (r_step != '0);
    assign o_done = r_done;
    assign o_q    = r_neg ? CRD_W'(-r_num[CRD_W-1:0]) : r_num[CRD_W-1:0];

endmodule

@@ rtl/core/kmeans_2d_cluster_engine_unit.sv @@
// Top level of the 2-D k-means engine: point memory, cell chain and sequencer.
// Load, set-centroid and clear requests are taken in the idle state and may follow
// back to back. A run first sends every stored point through the cell chain
// each round for assignment, then gives each non-empty cluster a pick step and
// two serial divisions and passes over each empty one; after the last round it
// emits one result per cluster while the output is accepted.
// Reset (synchronous, active low) empties the point store, zeroes centroids
// and tallies, and sets cluster_count to 2 and iteration_count to 10.
`timescale 1ns / 1ps
module kmeans_2d_cluster_engine_unit
    import kmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_res o_out_data,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // Widths that follow from the store sizes.
    localparam int IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int KW  = $clog2(MAX_CLUSTERS + 1);
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int PW  = $clog2(MAX_POINTS + 1);
    localparam int DRN = 2 * MAX_CLUSTERS + 3;
    localparam int DW  = $clog2(DRN + 1);

    t_state r_state, n_state;

    logic [4:0]    r_cc;
    logic [7:0]    r_iters, r_it;
    logic [KW-1:0] r_k, k_use;
    logic [PW-1:0] r_total, r_pidx;
    logic [IW-1:0] r_sel;
    logic [DW-1:0] r_drain;
    logic          r_rdv;
    logic [2*CRD_W-1:0] r_rd;
    logic signed [CRD_W-1:0] r_qx;
    logic          r_out_v;
    t_out_res      r_out;

    // Point store: x in the upper half of each word, z in the lower.
    logic [2*CRD_W-1:0] mem [MAX_POINTS];

    logic in_acc, out_acc, sel_last, round_last, issue_more;
    logic clr, div_start, div_busy, div_done, use_z;
    logic signed [CRD_W-1:0] div_q;
    t_cwr       cwr;
    t_cell_stat st;
    t_acc       acc;
    t_token     tok [MAX_CLUSTERS+1];
    t_cell_stat stat [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] act;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_v && i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // A zero cluster count acts as one, anything too large as the maximum.
    always_comb begin
        if (r_cc == '0) begin
            k_use = KW'(1);
        end else if (int'(r_cc) > MAX_CLUSTERS) begin
            k_use = KW'(MAX_CLUSTERS);
        end else begin
            k_use = KW'(r_cc);
        end
    end

    assign st         = stat[r_sel];
    assign sel_last   = (r_sel == IW'(r_k - 1'b1));
    assign round_last = ((r_it + 1'b1) == r_iters);
    assign issue_more = (r_pidx < r_total);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc    <= 5'd2;
            r_iters <= 8'd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CLUSTERS: r_cc    <= i_cfg_data[4:0];
                CFG_ITERS:    r_iters <= i_cfg_data;
                default:      r_cc    <= r_cc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and the strobes that steer the cells and divider.
    always_comb begin
        n_state   = r_state;
        clr       = 1'b0;
        div_start = 1'b0;
        use_z     = 1'b0;
        cwr       = '{we: 1'b0, idx: i_in_data.centroid_slot,
                      x: i_in_data.point_x, z: i_in_data.point_z};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_req'(i_in_data.req_type))
                        REQ_SET: begin
                            cwr.we = (int'(i_in_data.centroid_slot) < MAX_CLUSTERS);
                        end
                        REQ_RUN: begin
                            if (r_iters == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_ISSUE;
                                clr     = 1'b1;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ISSUE: begin
                if (!issue_more) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (st.tally != '0) begin
                    div_start = 1'b1;
                    n_state   = S_DIVX;
                end else if (sel_last) begin
                    if (round_last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ISSUE;
                        clr     = 1'b1;
                    end
                end
            end
            S_DIVX: begin
                use_z = 1'b1;
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIVZ;
                end
            end
            S_DIVZ: begin
                use_z = 1'b1;
                if (div_done) begin
                    cwr = '{we: 1'b1, idx: IDX_W'(r_sel), x: r_qx, z: div_q};
                    if (!sel_last) begin
                        n_state = S_PICK;
                    end else if (round_last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ISSUE;
                        clr     = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if ((!r_out_v || i_out_ready) && sel_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Counters, indices and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_pidx  <= '0;
            r_sel   <= '0;
            r_it    <= '0;
            r_k     <= KW'(1);
            r_drain <= '0;
            r_rdv   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_rdv <= (r_state == S_ISSUE) && issue_more;
            // In the emit state a new result is loaded whenever the output register is free or
            // being emptied; otherwise an accepted result frees it.
            if (r_state == S_EMIT && (!r_out_v || i_out_ready)) begin
                r_out_v <= 1'b1;
            end else if (out_acc) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (t_req'(i_in_data.req_type))
                            REQ_LOAD: begin
                                if (int'(r_total) < MAX_POINTS) begin
                                    r_total <= r_total + 1'b1;
                                end
                            end
                            REQ_CLEAR: r_total <= '0;
                            REQ_RUN: begin
                                r_k    <= k_use;
                                r_it   <= '0;
                                r_sel  <= '0;
                                r_pidx <= '0;
                            end
                            default: r_total <= r_total;
                        endcase
                    end
                end
                S_ISSUE: begin
                    if (issue_more) begin
                        r_pidx <= r_pidx + 1'b1;
                    end else begin
                        r_drain <= DW'(DRN);
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain - 1'b1;
                    r_sel   <= '0;
                end
                S_PICK, S_DIVZ: begin
                    if (n_state == S_PICK && r_state == S_DIVZ) begin
                        r_sel <= r_sel + 1'b1;
                    end else if (r_state == S_PICK && n_state == S_PICK) begin
                        r_sel <= r_sel + 1'b1;
                    end else if (n_state == S_ISSUE || n_state == S_EMIT) begin
                        r_sel  <= '0;
                        r_pidx <= '0;
                        r_it   <= r_it + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_v || i_out_ready) begin
                        r_sel <= r_sel + 1'b1;
                    end
                end
                default: r_sel <= r_sel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_out_v || i_out_ready)) begin
            r_out.centroid_index <= IDX_W'(r_sel);
            r_out.centroid_x     <= st.cx;
            r_out.centroid_z     <= st.cz;
            r_out.member_count   <= st.tally;
            r_out.cluster_empty  <= (st.tally == '0);
            r_out.last_result    <= sel_last;
        end
        if (r_state == S_DIVX && div_done) begin
            r_qx <= div_q;
        end
    end

    // Point memory: written on a load request, read while points are issued.
    always_ff @(posedge i_clk) begin
        if (in_acc && t_req'(i_in_data.req_type) == REQ_LOAD
                && int'(r_total) < MAX_POINTS) begin
            mem[r_total[AW-1:0]] <= {i_in_data.point_x, i_in_data.point_z};
        end
        r_rd <= mem[r_pidx[AW-1:0]];
    end

    // Each point enters the chain with no candidate yet; the cells keep the
    // nearest centroid, the lowest index winning a tie.
    assign tok[0] = '{valid: r_rdv, best_v: 1'b0,
                      x: r_rd[2*CRD_W-1:CRD_W], z: r_rd[CRD_W-1:0],
                      best_d: '0, best_idx: '0};

    assign acc = '{valid: tok[MAX_CLUSTERS].valid, idx: tok[MAX_CLUSTERS].best_idx,
                   x: tok[MAX_CLUSTERS].x, z: tok[MAX_CLUSTERS].z};

    // The cells in use follow the cluster count directly, so that the clear
    // issued with a run request already covers the clusters of that run.
    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        assign act[g] = (KW'(g) < k_use);
        kmc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_active   (act[g]),
            .i_clr      (clr),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1]),
            .i_acc      (acc),
            .i_cwr      (cwr),
            .o_stat     (stat[g])
        );
    end

    kmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (use_z ? st.sz : st.sx),
        .i_cnt   (st.tally),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // A point only leaves the chain while a round is being assigned.
    a_acc_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc.valid |-> (r_state == S_ISSUE || r_state == S_DRAIN))
        else $error("point left the chain outside assignment");

    // The divider works only for the centroid update.
    a_div_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIVX || r_state == S_DIVZ))
        else $error("divider busy outside update");

    // The issue pointer never passes the number of stored points.
    a_pidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pidx <= r_total)
        else $error("point issue pointer beyond store fill");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the 2-D k-means engine: predicts each run's centroids and compares.
`timescale 1ns / 1ps
module tb;
    import kmc_pkg::*;

    localparam int MAX_PTS   = 4096;
    localparam int MAX_CL    = 16;
    // The run ends early if the cycle counter reaches this figure.
    localparam int CYCLE_CAP = 3000000;
    // Cycles allowed after the last result before a register write.
    localparam int SETTLE    = 8;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_res o_out_data;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic     i_cfg_index;
    logic [7:0] i_cfg_data;

    kmeans_2d_cluster_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Our own copy of the engine's state, advanced as each request is accepted.
    logic signed [CRD_W-1:0] pt_x [MAX_PTS];
    logic signed [CRD_W-1:0] pt_z [MAX_PTS];
    int                      pt_count;
    logic signed [CRD_W-1:0] cen_x [MAX_CL];
    logic signed [CRD_W-1:0] cen_z [MAX_CL];
    int                      members [MAX_CL];
    logic [4:0]              k_setting;
    logic [7:0]              round_setting;

    t_out_res centroid_reports [$];

    int  mismatches;
    int  reports_seen;
    int  runs_sent;
    int  requests_sent;
    int  cycles;
    bit  calm;       // When set, neither side idles.
    int  hold_off;   // Cycles for which the receiver must refuse results.
    int  stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset is asserted first and all inputs start at known values.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CLUSTERS;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_CAP) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // The receiver: random stall bursts, plus a long hold-off when a test asks for one.
    initial begin
        i_out_ready = 1'b0;
        stall_left  = 0;
        hold_off    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                i_out_ready <= 1'b0;
                hold_off--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 15) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("Mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Every accepted result is compared with the oldest predicted centroid report.
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (centroid_reports.size() == 0) begin
                report_mismatch("unexpected result, index", o_out_data.centroid_index, -1);
            end else begin
                want = centroid_reports.pop_front();
                if (o_out_data.centroid_index !== want.centroid_index)
                    report_mismatch("centroid_index", o_out_data.centroid_index,
                                    want.centroid_index);
                if (o_out_data.centroid_x !== want.centroid_x)
                    report_mismatch("centroid_x", o_out_data.centroid_x, want.centroid_x);
                if (o_out_data.centroid_z !== want.centroid_z)
                    report_mismatch("centroid_z", o_out_data.centroid_z, want.centroid_z);
                if (o_out_data.member_count !== want.member_count)
                    report_mismatch("member_count", o_out_data.member_count,
                                    want.member_count);
                if (o_out_data.cluster_empty !== want.cluster_empty)
                    report_mismatch("cluster_empty", o_out_data.cluster_empty,
                                    want.cluster_empty);
                if (o_out_data.last_result !== want.last_result)
                    report_mismatch("last_result", o_out_data.last_result, want.last_result);
            end
        end
    end

    // Mean of a cluster, rounded to nearest with halves going away from zero.
    function automatic logic signed [CRD_W-1:0] cluster_mean(input longint total, input longint n);
        longint mag;
        longint q;
        mag = (total < 0) ? -total : total;
        q   = (2 * mag + n) / (2 * n);
        return (total < 0) ? CRD_W'(-q) : CRD_W'(q);
    endfunction

    // Carries out a whole run on the local state and queues one report per cluster.
    task automatic predict_run();
        int     k;
        int     best;
        longint best_d;
        longint d;
        longint dx;
        longint dz;
        longint acc_x [MAX_CL];
        longint acc_z [MAX_CL];
        t_out_res r;
        k = k_setting;
        if (k == 0) k = 1;
        if (k > MAX_CL) k = MAX_CL;
        for (int it = 0; it < round_setting; it++) begin
            for (int j = 0; j < k; j++) begin
                acc_x[j]   = 0;
                acc_z[j]   = 0;
                members[j] = 0;
            end
            for (int i = 0; i < pt_count; i++) begin
                best   = 0;
                best_d = 0;
                for (int j = 0; j < k; j++) begin
                    dx = longint'(pt_x[i]) - longint'(cen_x[j]);
                    dz = longint'(pt_z[i]) - longint'(cen_z[j]);
                    d  = dx * dx + dz * dz;
                    // Strict compare keeps ties on the lowest index.
                    if (j == 0 || d < best_d) begin
                        best_d = d;
                        best   = j;
                    end
                end
                acc_x[best] += pt_x[i];
                acc_z[best] += pt_z[i];
                members[best]++;
            end
            for (int j = 0; j < k; j++) begin
                if (members[j] != 0) begin
                    cen_x[j] = cluster_mean(acc_x[j], members[j]);
                    cen_z[j] = cluster_mean(acc_z[j], members[j]);
                end
            end
        end
        for (int j = 0; j < k; j++) begin
            r.centroid_index = IDX_W'(j);
            r.centroid_x     = cen_x[j];
            r.centroid_z     = cen_z[j];
            r.member_count   = CNT_W'(members[j]);
            r.cluster_empty  = (members[j] == 0);
            r.last_result    = (j == k - 1);
            centroid_reports = {centroid_reports, r};
        end
    endtask

    task automatic apply_request(input t_in_req r);
        case (t_req'(r.req_type))
            REQ_LOAD: begin
                if (pt_count < MAX_PTS) begin
                    pt_x[pt_count] = r.point_x;
                    pt_z[pt_count] = r.point_z;
                    pt_count++;
                end
            end
            REQ_SET: begin
                cen_x[r.centroid_slot] = r.point_x;
                cen_z[r.centroid_slot] = r.point_z;
            end
            REQ_CLEAR: pt_count = 0;
            default: begin
                predict_run();
                runs_sent++;
            end
        endcase
    endtask

    // Offers one request and returns in the step in which it is accepted. Valid stays
    // high between back-to-back requests, so only the payload changes.
    task automatic send_request(input t_in_req r);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
        apply_request(r);
    endtask

    task automatic send_typed(input t_req op, input int x, input int z, input int slot);
        t_in_req r;
        r.req_type      = op;
        r.point_x       = CRD_W'(x);
        r.point_z       = CRD_W'(z);
        r.centroid_slot = IDX_W'(slot);
        send_request(r);
    endtask

    // Stops offering and waits until every expected report has arrived.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (centroid_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input int value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 8'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CLUSTERS) k_setting = 5'(value);
        else round_setting = 8'(value);
    endtask

    // Reset state, zero rounds, coordinate extremes, ties and rounding halves, and clear.
    task automatic test_directed();
        send_typed(REQ_RUN, 0, 0, 0);            // no points: every cluster empty
        write_register(CFG_ITERS, 0);
        send_typed(REQ_SET, 100, -100, 1);
        send_typed(REQ_RUN, 0, 0, 0);            // zero rounds: centroids unchanged
        write_register(CFG_ITERS, 3);
        write_register(CFG_CLUSTERS, 16);
        send_typed(REQ_SET, -32768, -32768, 0);
        send_typed(REQ_SET, 32767, 32767, 15);
        send_typed(REQ_SET, 32767, -32768, 7);
        send_typed(REQ_LOAD, -32768, -32768, 0);
        send_typed(REQ_LOAD, 32767, 32767, 0);
        send_typed(REQ_LOAD, 32767, -32768, 0);
        send_typed(REQ_LOAD, -32768, 32767, 0);
        send_typed(REQ_RUN, 0, 0, 0);
        // Equidistant point goes to the lower index; halves round away from zero.
        write_register(CFG_CLUSTERS, 2);
        write_register(CFG_ITERS, 1);
        send_typed(REQ_CLEAR, 0, 0, 0);
        send_typed(REQ_SET, -256, 0, 0);
        send_typed(REQ_SET, 256, 0, 1);
        send_typed(REQ_LOAD, 0, 0, 0);
        send_typed(REQ_LOAD, -1, 1, 0);
        send_typed(REQ_LOAD, -2, 2, 0);
        send_typed(REQ_LOAD, 1, -1, 0);
        send_typed(REQ_LOAD, 2, -2, 0);
        send_typed(REQ_RUN, 0, 0, 0);
        send_typed(REQ_CLEAR, 0, 0, 0);
        send_typed(REQ_RUN, 0, 0, 0);            // cleared store: all clusters empty
    endtask

    // Out-of-range cluster counts and the longest round count.
    task automatic test_register_extremes();
        write_register(CFG_CLUSTERS, 0);
        write_register(CFG_ITERS, 2);
        for (int i = 0; i < 6; i++)
            send_typed(REQ_LOAD, $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000, 0);
        send_typed(REQ_RUN, 0, 0, 0);
        write_register(CFG_CLUSTERS, 31);
        send_typed(REQ_RUN, 0, 0, 0);
        write_register(CFG_CLUSTERS, 17);
        write_register(CFG_ITERS, 255);
        send_typed(REQ_RUN, 0, 0, 0);
        write_register(CFG_CLUSTERS, 1);
        send_typed(REQ_RUN, 0, 0, 0);
    endtask

    // One well-formed clustering job with random content, sometimes with stray noise.
    task automatic random_job(inout int budget);
        int k;
        int n;
        int cx;
        int cz;
        int spread;
        k = $urandom_range(1, 16);
        write_register(CFG_CLUSTERS, k);
        write_register(CFG_ITERS, $urandom_range(0, 5));
        if ($urandom_range(0, 3) != 0) begin
            send_typed(REQ_CLEAR, 0, 0, 0);
            budget--;
        end
        for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 2) != 0) begin
                send_typed(REQ_SET, $urandom, $urandom, j);
                budget--;
            end
        end
        n = $urandom_range(3, 20);
        spread = $urandom_range(0, 1) ? 65535 : 2000;
        cx = $urandom_range(0, 65535) - 32768;
        cz = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < n; i++) begin
            if (spread == 65535)
                send_typed(REQ_LOAD, $urandom, $urandom, $urandom);
            else
                send_typed(REQ_LOAD, cx + $urandom_range(0, spread) - spread / 2,
                           cz + $urandom_range(0, spread) - spread / 2, $urandom);
            budget--;
        end
        if ($urandom_range(0, 4) == 0) begin
            send_typed(REQ_SET, $urandom, $urandom, $urandom);  // stray write, any slot
            budget--;
        end
        send_typed(REQ_RUN, $urandom, $urandom, $urandom);
        budget--;
    endtask

    task automatic test_random(input int count);
        int budget;
        budget = count;
        while (budget > 0) random_job(budget);
    endtask

    // Holds results back for a long stretch while requests keep coming, then lets the
    // sender wait for a complete drain.
    task automatic test_backpressure();
        write_register(CFG_CLUSTERS, 16);
        write_register(CFG_ITERS, 1);
        hold_off = 600;
        send_typed(REQ_RUN, 0, 0, 0);
        for (int i = 0; i < 10; i++) send_typed(REQ_LOAD, $urandom, $urandom, 0);
        send_typed(REQ_RUN, 0, 0, 0);
        for (int i = 0; i < 5; i++) send_typed(REQ_LOAD, $urandom, $urandom, 0);
        wait_idle();
    endtask

    initial begin
        mismatches    = 0;
        reports_seen  = 0;
        runs_sent     = 0;
        requests_sent = 0;
        calm          = 1'b0;
        pt_count      = 0;
        k_setting     = 5'd2;
        round_setting = 8'd10;
        for (int j = 0; j < MAX_CL; j++) begin
            cen_x[j]   = '0;
            cen_z[j]   = '0;
            members[j] = 0;
        end
        @(posedge i_rst_n);
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random(70);
        // The closing stretch runs without any idling on either side.
        calm = 1'b1;
        test_random(30);
        wait_idle();

        $display("Covered %0d requests including %0d runs, %0d centroid reports checked.",
                 requests_sent, runs_sent, reports_seen);
        $display("Included empty store, zero and 255 rounds, cluster counts 0 to 31, long output stall.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
